@@ hw/rtl/tgrs_pkg.sv @@
package tgrs_pkg;

  localparam int MAX_STEPS   = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int STEP_W    = 12;
  localparam int SEL_W     = 13;
  localparam int GEN_W     = 5;
  localparam int GEN_MAX   = 16;
  localparam int PROD_W    = 2 * (GEN_W - 1) + 1;
  localparam int LEN_MUL_W = PROD_W + GEN_W;
  localparam int LEN_W     = $clog2(MAX_STEPS + 1);
  localparam int DIV_W     = (SEL_W > LEN_W) ? SEL_W : LEN_W;
  localparam int MOD_CTR_W = $clog2(DIV_W);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GEN_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GEN_C = CFG_IDX_W'(2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen_a;
    logic [GEN_W-1:0]  gen_b;
    logic [GEN_W-1:0]  gen_c;
    logic [PROD_W-1:0] prod_ab;
    logic [PROD_W-1:0] prod_ac;
    logic [PROD_W-1:0] prod_bc;
    logic [LEN_W-1:0]  len;
  } gen_set_t;

endpackage

@@ hw/rtl/tgrs_cfg.sv @@
module tgrs_cfg import tgrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [CFG_IDX_W-1:0] idx,
  input  logic [GEN_W-1:0]     data,
  output gen_set_t             gs
);

  logic [GEN_W-1:0]     gen_a_r, gen_b_r, gen_c_r;
  logic [PROD_W-1:0]    ab_r, ac_r, bc_r;
  logic [GEN_W-1:0]     gen_nxt;
  logic [LEN_MUL_W-1:0] len_full;

  always_comb begin
    if (data == '0) begin
      gen_nxt = GEN_W'(1);
    end else if (int'(data) > GEN_MAX) begin
      gen_nxt = GEN_W'(GEN_MAX);
    end else begin
      gen_nxt = data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_a_r <= GEN_W'(1);
      gen_b_r <= GEN_W'(1);
      gen_c_r <= GEN_W'(1);
      ab_r    <= PROD_W'(1);
      ac_r    <= PROD_W'(1);
      bc_r    <= PROD_W'(1);
    end else begin
      if (we) begin
        unique case (idx)
          REG_GEN_A: gen_a_r <= gen_nxt;
          REG_GEN_B: gen_b_r <= gen_nxt;
          REG_GEN_C: gen_c_r <= gen_nxt;
          default: ;
        endcase
      end
      ab_r <= PROD_W'(gen_a_r * gen_b_r);
      ac_r <= PROD_W'(gen_a_r * gen_c_r);
      bc_r <= PROD_W'(gen_b_r * gen_c_r);
    end
  end

  // ab is registered, so only one multiply feeds the divisor register
  assign len_full = LEN_MUL_W'(ab_r * gen_c_r);

  always_comb begin
    gs.gen_a   = gen_a_r;
    gs.gen_b   = gen_b_r;
    gs.gen_c   = gen_c_r;
    gs.prod_ab = ab_r;
    gs.prod_ac = ac_r;
    gs.prod_bc = bc_r;
    if (int'(len_full) > MAX_STEPS) begin
      gs.len = LEN_W'(MAX_STEPS);
    end else if (len_full == '0) begin
      gs.len = LEN_W'(1);
    end else begin
      gs.len = LEN_W'(len_full);
    end
  end

endmodule

@@ hw/rtl/tgrs_mod_unit.sv @@
module tgrs_mod_unit import tgrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                 busy_r, done_r;
  logic [MOD_CTR_W-1:0] ctr_r;
  logic [DIV_W-1:0]     rem_r, dvd_r, dsr_r;
  logic [DIV_W:0]       trial;
  logic [DIV_W-1:0]     rem_nxt;
  logic                 last_bit;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  assign last_bit = (ctr_r == MOD_CTR_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ctr_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && last_bit;
      if (req.start) begin
        busy_r <= 1'b1;
        ctr_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
        if (last_bit) begin
          busy_r <= 1'b0;
        end else begin
          ctr_r <= ctr_r + MOD_CTR_W'(1);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ hw/rtl/three_generator_rhythm_sequencer.sv @@
// Three-generator rhythm sequencer. Each accepted request (clock sample, reset click,
// step select) updates a step counter that runs modulo gen_a*gen_b*gen_c and
// yields one result: the clock sample gated by the a, b, c, bc, ac and ab
// patterns and their two resultants, the clock echo, a cycle-start flag and the
// step number. A request makes seven passes (counter update, then six pattern
// checks) through one shared remainder unit that resolves one bit per cycle over
// 13 bits, then loads the result register; the next request is taken only once
// the block is back in its idle state. The result register holds a stalled
// result while the next request is computed; a result still stalled when the
// next one is ready holds the block until it is taken.
// Generator writes are taken while no request is in progress; a write of 0 reads
// as 1 and a value above 16 as 16.
module three_generator_rhythm_sequencer import tgrs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_clock_sample,
  input  logic                          in_reset_click,
  input  logic [SEL_W-1:0]              in_step_select,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_resultant_gated,
  output logic signed [SAMPLE_BITS-1:0] out_a_gated,
  output logic signed [SAMPLE_BITS-1:0] out_b_gated,
  output logic signed [SAMPLE_BITS-1:0] out_c_gated,
  output logic signed [SAMPLE_BITS-1:0] out_counter_resultant_gated,
  output logic signed [SAMPLE_BITS-1:0] out_bc_gated,
  output logic signed [SAMPLE_BITS-1:0] out_ac_gated,
  output logic signed [SAMPLE_BITS-1:0] out_ab_gated,
  output logic signed [SAMPLE_BITS-1:0] out_clock_echo,
  output logic                          out_cycle_start,
  output logic [STEP_W-1:0]             out_step_number,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [GEN_W-1:0]              cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_RUN, S_EMIT} state_t;
  typedef enum logic [2:0] {JOB_STEP, JOB_A, JOB_B, JOB_C, JOB_BC, JOB_AC, JOB_AB} job_t;

  state_t            state_r;
  job_t              job_r;
  sample_t           clk_r;
  logic              rst_r;
  logic [SEL_W-1:0]  sel_r, last_r;
  logic [STEP_W-1:0] cnt_r;
  logic [5:0]        hit_r;
  logic [2:0]        hit_idx;
  logic              clk_pos, jump, r1, r2;

  sample_t           res_r, a_r, b_r, c_r, cres_r, bc_r, ac_r, ab_r, echo_r;
  logic              out_valid_r, cstart_r;
  logic [STEP_W-1:0] stepn_r;

  gen_set_t gs;
  mod_req_t req;
  mod_rsp_t rsp;

  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);

  tgrs_cfg u_cfg (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (cfg_valid && cfg_ready),
    .idx  (cfg_index),
    .data (cfg_data),
    .gs   (gs)
  );

  tgrs_mod_unit u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign clk_pos = !clk_r[SAMPLE_BITS-1] && (clk_r != '0);
  assign jump    = (sel_r != last_r) && (sel_r != '0);
  assign hit_idx = 3'(job_r) - 3'd1;
  assign r1      = hit_r[0] || hit_r[1] || hit_r[2];
  assign r2      = hit_r[3] || hit_r[4] || hit_r[5];

  always_comb begin
    req.start    = (state_r == S_START);
    req.dividend = DIV_W'(cnt_r);
    unique case (job_r)
      JOB_STEP: begin
        req.divisor = DIV_W'(gs.len);
        if (jump) begin
          req.dividend = DIV_W'(sel_r) - DIV_W'(1);
        end else if (rst_r) begin
          req.dividend = '0;
        end else begin
          req.dividend = DIV_W'(cnt_r) + DIV_W'(clk_pos);
        end
      end
      JOB_A:   req.divisor = DIV_W'(gs.gen_a);
      JOB_B:   req.divisor = DIV_W'(gs.gen_b);
      JOB_C:   req.divisor = DIV_W'(gs.gen_c);
      JOB_BC:  req.divisor = DIV_W'(gs.prod_bc);
      JOB_AC:  req.divisor = DIV_W'(gs.prod_ac);
      JOB_AB:  req.divisor = DIV_W'(gs.prod_ab);
      default: req.divisor = DIV_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_STEP;
      last_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            clk_r   <= in_clock_sample;
            rst_r   <= in_reset_click;
            sel_r   <= in_step_select;
            job_r   <= JOB_STEP;
            state_r <= S_START;
          end
        end
        S_START: begin
          if (job_r == JOB_STEP) begin
            last_r <= sel_r;
          end
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (rsp.done) begin
            if (job_r == JOB_STEP) begin
              cnt_r <= rsp.rem[STEP_W-1:0];
            end else begin
              hit_r[hit_idx] <= (rsp.rem == '0);
            end
            if (job_r == JOB_AB) begin
              state_r <= S_EMIT;
            end else begin
              job_r   <= job_t'(3'(job_r) + 3'd1);
              state_r <= S_START;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            res_r       <= r1 ? clk_r : '0;
            a_r         <= hit_r[0] ? clk_r : '0;
            b_r         <= hit_r[1] ? clk_r : '0;
            c_r         <= hit_r[2] ? clk_r : '0;
            cres_r      <= r2 ? clk_r : '0;
            bc_r        <= hit_r[3] ? clk_r : '0;
            ac_r        <= hit_r[4] ? clk_r : '0;
            ab_r        <= hit_r[5] ? clk_r : '0;
            echo_r      <= clk_r;
            cstart_r    <= (cnt_r == '0) && (clk_r != '0);
            stepn_r     <= cnt_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_resultant_gated         = res_r;
  assign out_a_gated                 = a_r;
  assign out_b_gated                 = b_r;
  assign out_c_gated                 = c_r;
  assign out_counter_resultant_gated = cres_r;
  assign out_bc_gated                = bc_r;
  assign out_ac_gated                = ac_r;
  assign out_ab_gated                = ab_r;
  assign out_clock_echo              = echo_r;
  assign out_cycle_start             = cstart_r;
  assign out_step_number             = stepn_r;

endmodule

@@ hw/rtl/tgrs_checker.sv @@
module tgrs_checker import tgrs_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_resultant_gated,
  input logic signed [SAMPLE_BITS-1:0] out_counter_resultant_gated,
  input logic signed [SAMPLE_BITS-1:0] out_clock_echo,
  input logic                          out_cycle_start,
  input logic [STEP_W-1:0]             out_step_number,
  input logic                          cfg_ready
);

  // a request keeps the block busy, so no back-to-back accept or cfg write
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !cfg_ready))
    else $error("block took a request or cfg write right after a request");

  a_cycle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cycle_start) |-> (out_step_number == '0 && out_clock_echo != '0))
    else $error("cycle start without step zero and a nonzero clock");

  a_resultant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_resultant_gated == out_clock_echo || out_resultant_gated == '0)
      && (out_counter_resultant_gated == out_clock_echo
          || out_counter_resultant_gated == '0)))
    else $error("resultant is neither the clock nor zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_step_number)))
    else $error("stalled result dropped or changed");

endmodule

bind three_generator_rhythm_sequencer tgrs_checker u_tgrs_checker (.*);

@@ sim/tb_three_generator_rhythm_sequencer.sv @@
module tb_three_generator_rhythm_sequencer;
  import tgrs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int N_LANES = 9;

  typedef struct {
    sample_t           clock_sample;
    logic              reset_click;
    logic [SEL_W-1:0]  step_select;
  } frame_t;

  // lanes: resultant, a, b, c, counter resultant, bc, ac, ab, clock echo
  typedef struct {
    sample_t           lane [N_LANES];
    logic              cycle_start;
    logic [STEP_W-1:0] step_number;
  } step_result_t;

  class step_scoreboard;
    int unsigned       gen [3];
    int unsigned       cycle_len;
    logic [STEP_W-1:0] step_count;
    logic [SEL_W-1:0]  last_select;
    step_result_t      queued_results [$];
    int                errors;
    string             lane_name [N_LANES];

    function new();
      gen = '{1, 1, 1};
      cycle_len = 1;
      step_count = '0;
      last_select = '0;
      errors = 0;
      lane_name = '{"resultant_gated", "a_gated", "b_gated", "c_gated",
                    "counter_resultant_gated", "bc_gated", "ac_gated", "ab_gated",
                    "clock_echo"};
    endfunction

    function void load_generator(logic [CFG_IDX_W-1:0] idx, logic [GEN_W-1:0] data);
      int unsigned v;
      v = (data == 0) ? 1 : (data > GEN_MAX) ? GEN_MAX : data;
      case (idx)
        REG_GEN_A: gen[0] = v;
        REG_GEN_B: gen[1] = v;
        REG_GEN_C: gen[2] = v;
        default: return;
      endcase
      cycle_len = gen[0] * gen[1] * gen[2];
      if (cycle_len > MAX_STEPS) cycle_len = MAX_STEPS;
    endfunction

    function void take_frame(frame_t f);
      int unsigned  cnt;
      int unsigned  period [6];
      bit           hit [6];
      sample_t      s;
      step_result_t r;
      cnt = step_count;
      if (f.clock_sample > 0) cnt++;
      cnt = cnt % cycle_len;
      if (f.reset_click) cnt = 0;
      // jump beats reset click; only a change to nonzero jumps
      if (f.step_select != last_select && f.step_select != 0)
        cnt = (int'(f.step_select) - 1) % cycle_len;
      last_select = f.step_select;
      step_count = cnt[STEP_W-1:0];
      period = '{gen[0], gen[1], gen[2], gen[1] * gen[2], gen[0] * gen[2], gen[0] * gen[1]};
      for (int i = 0; i < 6; i++) hit[i] = (step_count % period[i]) == 0;
      s = f.clock_sample;
      r.lane[0] = (hit[0] || hit[1] || hit[2]) ? s : '0;
      r.lane[1] = hit[0] ? s : '0;
      r.lane[2] = hit[1] ? s : '0;
      r.lane[3] = hit[2] ? s : '0;
      r.lane[4] = (hit[3] || hit[4] || hit[5]) ? s : '0;
      r.lane[5] = hit[3] ? s : '0;
      r.lane[6] = hit[4] ? s : '0;
      r.lane[7] = hit[5] ? s : '0;
      r.lane[8] = s;
      r.cycle_start = (step_count == 0) && (s != 0);
      r.step_number = step_count;
      queued_results.push_back(r);
    endfunction

    function void complain(string what, logic signed [31:0] want, logic signed [31:0] got);
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (queued_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no request pending, step %0d", got.step_number);
        return;
      end
      want = queued_results.pop_front();
      for (int i = 0; i < N_LANES; i++)
        if (got.lane[i] !== want.lane[i]) complain(lane_name[i], want.lane[i], got.lane[i]);
      if (got.cycle_start !== want.cycle_start)
        complain("cycle_start", want.cycle_start, got.cycle_start);
      if (got.step_number !== want.step_number)
        complain("step_number", want.step_number, got.step_number);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  sample_t              in_clock_sample;
  logic                 in_reset_click;
  logic [SEL_W-1:0]     in_step_select;
  logic                 out_valid;
  logic                 out_stall;
  sample_t              out_resultant_gated;
  sample_t              out_a_gated;
  sample_t              out_b_gated;
  sample_t              out_c_gated;
  sample_t              out_counter_resultant_gated;
  sample_t              out_bc_gated;
  sample_t              out_ac_gated;
  sample_t              out_ab_gated;
  sample_t              out_clock_echo;
  logic                 out_cycle_start;
  logic [STEP_W-1:0]    out_step_number;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GEN_W-1:0]     cfg_data;

  step_scoreboard sb = new();
  bit calm = 1'b0;

  three_generator_rhythm_sequencer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin : watch
    step_result_t got;
    frame_t       f;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.lane = '{out_resultant_gated, out_a_gated, out_b_gated, out_c_gated,
                     out_counter_resultant_gated, out_bc_gated, out_ac_gated,
                     out_ab_gated, out_clock_echo};
        got.cycle_start = out_cycle_start;
        got.step_number = out_step_number;
        sb.check_result(got);
      end
      if (cfg_valid && cfg_ready) sb.load_generator(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        f.clock_sample = in_clock_sample;
        f.reset_click = in_reset_click;
        f.step_select = in_step_select;
        sb.take_frame(f);
      end
    end
  end

  // result-side backpressure
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 20))
        @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // leaves in_valid high so back-to-back requests need no extra edge
  task automatic send_frame(sample_t c, logic r, logic [SEL_W-1:0] s);
    in_valid <= 1'b1;
    in_clock_sample <= c;
    in_reset_click <= r;
    in_step_select <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.queued_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int n);
    logic [SEL_W-1:0] held;
    logic [SEL_W-1:0] sel;
    sample_t          c;
    int               pick;
    held = sb.last_select;
    for (int k = 0; k < n; k++) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) c = sample_t'($urandom_range(1, 32767));
      else if (pick < 80) c = '0;
      else if (pick < 88) c = sample_t'(16'h8000 | $urandom_range(0, 32767));
      else if (pick < 94) c = sample_t'($urandom);
      else case ($urandom_range(0, 3))
        0: c = 16'sh7fff;
        1: c = 16'sh8000;
        2: c = 16'sh0001;
        default: c = 16'shffff;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 80) sel = held;
      else if (pick < 88) sel = '0;
      else if (pick < 97) sel = SEL_W'($urandom_range(1, sb.cycle_len));
      else sel = SEL_W'($urandom_range(0, 8191));
      held = sel;
      send_frame(c, $urandom_range(0, 29) == 0, sel);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_clock_sample = '0;
    in_reset_click = 1'b0;
    in_step_select = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GEN_A;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset generators: every pattern hits
    send_frame(16'sh0000, 1'b0, 13'd0);
    send_frame(16'sh0001, 1'b0, 13'd0);
    send_frame(16'sh7fff, 1'b0, 13'd0);
    send_frame(16'sh8000, 1'b0, 13'd0);
    send_frame(16'shffff, 1'b0, 13'd0);
    drain();

    write_reg(REG_GEN_A, 5'd2);
    write_reg(REG_GEN_B, 5'd3);
    write_reg(REG_GEN_C, 5'd5);
    send_frame(16'sh4000, 1'b1, 13'd0);
    send_frame(16'sd100, 1'b0, 13'd30);   // last step
    send_frame(16'sd100, 1'b0, 13'd30);   // held select, wraps to zero
    send_frame(16'sh0000, 1'b0, 13'd0);
    send_frame(-16'sd5, 1'b0, 13'd5);
    send_frame(16'sd7, 1'b1, 13'd9);      // jump wins over reset click
    send_frame(16'sd7, 1'b1, 13'd9);
    send_frame(16'sd1, 1'b0, 13'd8191);   // select beyond cycle wraps
    send_frame(16'sd1, 1'b0, 13'd4096);
    send_frame(16'sh8000, 1'b0, 13'd1);
    send_frame(16'sh0000, 1'b0, 13'd1);
    send_frame(16'sd3, 1'b0, 13'd30);
    drain();

    // shrink cycle under a live counter
    write_reg(REG_GEN_A, 5'd2);
    write_reg(REG_GEN_B, 5'd2);
    write_reg(REG_GEN_C, 5'd2);
    send_frame(16'sh0000, 1'b0, 13'd30);
    send_frame(16'sd9, 1'b0, 13'd0);
    drain();

    // out-of-range generator values and an unmapped index
    write_reg(REG_GEN_A, 5'd0);
    write_reg(REG_GEN_B, 5'd31);
    write_reg(REG_GEN_C, 5'd17);
    write_reg(REG_UNUSED, 5'd5);
    send_frame(16'sd2, 1'b0, 13'd0);
    send_frame(16'sd2, 1'b0, 13'd256);
    send_frame(16'sd2, 1'b0, 13'd0);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          write_reg(REG_GEN_A, 5'd16);
          write_reg(REG_GEN_B, 5'd16);
          write_reg(REG_GEN_C, 5'd16);
        end
        1: begin
          write_reg(REG_GEN_A, 5'd1);
          write_reg(REG_GEN_B, 5'd1);
          write_reg(REG_GEN_C, 5'd1);
        end
        default: begin
          write_reg(REG_GEN_A, GEN_W'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                                   : $urandom_range(0, 31)));
          write_reg(REG_GEN_B, GEN_W'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                                   : $urandom_range(0, 31)));
          write_reg(REG_GEN_C, GEN_W'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                                   : $urandom_range(0, 31)));
        end
      endcase
      write_reg(REG_UNUSED, GEN_W'($urandom_range(0, 31)));
      calm = (p == 9);
      run_phase(190);
      drain();
    end

    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.queued_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
